### sv/lru_sac_pkg.sv
package lru_sac_pkg;

  localparam int ADDR_W = 64;
  localparam int CNT_W  = 32;

  localparam logic [1:0] ACT_IFETCH = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_STORE  = 2'd2;
  localparam logic [1:0] ACT_MODIFY = 2'd3;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

### sv/lru_set_assoc_cache_sim.sv
// Set-associative cache model with true LRU replacement.
// Input stream: in_tuser carries the access kind, in_tdata the 64-bit byte
// address. Each beat yields exactly one output beat with the hits, miss and
// eviction flags of that access and the saturating running totals.
// Configuration (set bits, block bits, ways in use) is written through the
// cfg_ port; the user must write it only while no access is in flight, as
// the block does not enforce this; values take effect on the next beat.
// The set is read from memory at the accepting edge; the lookup then waits for
// a free output register, writes the set back and loads the result into it.
// The tag/rank/valid memory is read once and written at most once per item.
// The next input beat is taken while a finished result still waits in the
// output register; if the receiver stalls, the lookup stage holds until the
// output register frees, and input stalls behind it.
// Reset: rst_n (synchronous, active low) clears the per-set init flags, so
// every set reads as empty with ranks equal to way index, clears the totals
// and the configuration to set_bits 0, block_bits 0, ways_in_use 1. No
// clearing pass is needed; the block is ready the cycle after reset.
module lru_set_assoc_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [4:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [63:0] address
  input  logic [1:0]   in_tuser,   // [1:0] action
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] hits_added, [2] missed, [3] evicted, [35:4] total_hits,
  // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
  output logic [103:0] out_tdata
);
  import lru_sac_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int EW = $clog2(MAX_WAYS + 1) + 1;
  localparam logic [RW-1:0] RANK_TOP = RW'(MAX_WAYS - 1);

  typedef logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_row_t;
  typedef logic [MAX_WAYS-1:0][RW-1:0]     rank_row_t;

  // memories: one row per set
  tag_row_t            tag_mem  [NUM_SETS];
  rank_row_t           rank_mem [NUM_SETS];
  logic [MAX_WAYS-1:0] vld_mem  [NUM_SETS];
  logic [NUM_SETS-1:0] row_init_r;

  tag_row_t            rd_tag_r;
  rank_row_t           rd_rank_r;
  logic [MAX_WAYS-1:0] rd_vld_r;
  logic                rd_init_r;

  logic [2:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_r;

  state_t state_r, state_nxt;
  logic [1:0]        act_r;
  logic [SW-1:0]     set_r;
  logic [ADDR_W-1:0] tag_r;

  logic [CNT_W-1:0] hit_tot_r, miss_tot_r, ev_tot_r;
  logic [CNT_W-1:0] hit_tot_nxt, miss_tot_nxt, ev_tot_nxt;
  logic             out_valid_r;
  logic [1:0]       o_hits_r, o_hits_nxt;
  logic             o_miss_r, o_miss_nxt, o_ev_r, o_ev_nxt;

  // address split
  logic [4:0]        s_eff;
  logic [5:0]        shift;
  logic [ADDR_W-1:0] in_tag, set_mask, set_full;
  logic [SW-1:0]     in_set;
  logic [EW-1:0]     e_eff;

  always_comb begin
    s_eff = (5'(set_bits_r) > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : 5'(set_bits_r);
    shift = 6'(s_eff) + 6'(block_bits_r);
    in_tag = in_tdata >> shift;
    set_mask = ~({ADDR_W{1'b1}} << s_eff);
    set_full = (in_tdata >> block_bits_r) & set_mask;
    in_set = set_full[SW-1:0];
    if (ways_r == 4'd0) begin
      e_eff = EW'(1);
    end else if (EW'(ways_r) > EW'(MAX_WAYS)) begin
      e_eff = EW'(MAX_WAYS);
    end else begin
      e_eff = EW'(ways_r);
    end
  end

  // lookup on the read row
  rank_row_t           cur_rank, new_rank;
  logic [MAX_WAYS-1:0] cur_vld, new_vld, hit_vec;
  tag_row_t            new_tag;
  logic                hit, found_inv, evict;
  logic [RW-1:0]       tgt, vic, old_rank, min_rank;
  logic                look_go, do_acc;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      cur_rank[w] = rd_init_r ? rd_rank_r[w] : RW'(w);
      cur_vld[w]  = rd_init_r ? rd_vld_r[w] : 1'b0;
      hit_vec[w]  = cur_vld[w] && (rd_tag_r[w] == tag_r) && (EW'(w) < e_eff);
    end
    hit = |hit_vec;
    tgt = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) tgt = RW'(w);
    end
    // lowest invalid way, else least recent way
    found_inv = 1'b0;
    vic = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((EW'(w) < e_eff) && !cur_vld[w]) begin
        found_inv = 1'b1;
        vic = RW'(w);
      end
    end
    min_rank = cur_rank[0];
    if (!found_inv) begin
      vic = '0;
      for (int w = 1; w < MAX_WAYS; w++) begin
        if ((EW'(w) < e_eff) && (cur_rank[w] < min_rank)) begin
          vic = RW'(w);
          min_rank = cur_rank[w];
        end
      end
    end
    evict = !hit && !found_inv;
    if (!hit) tgt = vic;

    old_rank = cur_rank[tgt];
    new_vld = cur_vld;
    new_tag = rd_tag_r;
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_rank[w] = (cur_rank[w] > old_rank) ? cur_rank[w] - RW'(1) : cur_rank[w];
    end
    new_rank[tgt] = RANK_TOP;
    new_vld[tgt] = 1'b1;
    new_tag[tgt] = tag_r;
  end

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  // control and result
  always_comb begin
    state_nxt = state_r;
    in_tready = (state_r == ST_IDLE);
    look_go = (state_r == ST_LOOK) && (!out_valid_r || out_tready);
    do_acc = look_go && (act_r != ACT_IFETCH);
    hit_tot_nxt = hit_tot_r;
    miss_tot_nxt = miss_tot_r;
    ev_tot_nxt = ev_tot_r;
    o_hits_nxt = 2'd0;
    o_miss_nxt = 1'b0;
    o_ev_nxt = 1'b0;
    if (act_r != ACT_IFETCH) begin
      if (hit) begin
        o_hits_nxt = 2'd1;
        hit_tot_nxt = sat_inc(hit_tot_nxt);
      end else begin
        o_miss_nxt = 1'b1;
        miss_tot_nxt = sat_inc(miss_tot_nxt);
        if (evict) begin
          o_ev_nxt = 1'b1;
          ev_tot_nxt = sat_inc(ev_tot_nxt);
        end
      end
      // second half of a modify always hits
      if (act_r == ACT_MODIFY) begin
        o_hits_nxt = o_hits_nxt + 2'd1;
        hit_tot_nxt = sat_inc(hit_tot_nxt);
      end
    end
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_LOOK;
      ST_LOOK: if (look_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      set_bits_r <= 3'd0;
      block_bits_r <= 5'd0;
      ways_r <= 4'd1;
      row_init_r <= '0;
      hit_tot_r <= '0;
      miss_tot_r <= '0;
      ev_tot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SET_BITS:   set_bits_r <= cfg_wdata[2:0];
          REG_BLOCK_BITS: block_bits_r <= cfg_wdata;
          REG_WAYS:       ways_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (do_acc) row_init_r[set_r] <= 1'b1;
      if (look_go) begin
        hit_tot_r <= hit_tot_nxt;
        miss_tot_r <= miss_tot_nxt;
        ev_tot_r <= ev_tot_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memory read at accept, write back at end of lookup
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      rd_tag_r <= tag_mem[in_set];
      rd_rank_r <= rank_mem[in_set];
      rd_vld_r <= vld_mem[in_set];
      rd_init_r <= row_init_r[in_set];
      act_r <= in_tuser;
      set_r <= in_set;
      tag_r <= in_tag;
    end
    if (do_acc) begin
      tag_mem[set_r] <= new_tag;
      rank_mem[set_r] <= new_rank;
      vld_mem[set_r] <= new_vld;
    end
    if (look_go) begin
      o_hits_r <= o_hits_nxt;
      o_miss_r <= o_miss_nxt;
      o_ev_r <= o_ev_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'd0, ev_tot_r, miss_tot_r, hit_tot_r, o_ev_r, o_miss_r, o_hits_r};

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lru_sac_pkg::*;

  localparam int N_SETS = 64;
  localparam int N_WAYS = 8;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  hits_added;
    logic        missed;
    logic        evicted;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
  } access_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = REG_SET_BITS;
  logic [4:0]   cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;   // [63:0] address
  logic [1:0]   in_tuser = ACT_IFETCH;   // [1:0] action
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [1:0] hits_added, [2] missed, [3] evicted, [35:4] total_hits,
  // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
  logic [103:0] out_tdata;

  // Shadow copy of the cache state and configuration.
  bit          sh_valid[N_SETS][N_WAYS];
  logic [63:0] sh_tag[N_SETS][N_WAYS];
  int unsigned sh_rank[N_SETS][N_WAYS];
  logic [31:0] sh_hits, sh_misses, sh_evicts;
  int unsigned cf_set_bits, cf_block_bits, cf_ways;

  access_result_t expected_results[$];
  bit failed = 1'b0;
  bit hold_off = 1'b0;   // forces the receiver to stall
  int idle_cycles = 0;

  lru_set_assoc_cache_sim i_dut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] sat_add(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void promote_way(int s, int w);
    int unsigned prev;
    prev = sh_rank[s][w];
    for (int i = 0; i < N_WAYS; i++)
      if (sh_rank[s][i] > prev) sh_rank[s][i]--;
    sh_rank[s][w] = N_WAYS - 1;
  endfunction

  // One lookup in the shadow cache; returns 1 on hit, sets ev on replacement.
  function automatic bit lookup_line(logic [63:0] addr, output bit ev);
    int unsigned sb, nw, shamt, victim;
    int s;
    logic [63:0] tg;
    sb = (cf_set_bits > 6) ? 6 : cf_set_bits;
    nw = (cf_ways == 0) ? 1 : ((cf_ways > N_WAYS) ? N_WAYS : cf_ways);
    shamt = sb + cf_block_bits;
    tg = (shamt >= 64) ? 64'd0 : (addr >> shamt);
    s = int'((addr >> cf_block_bits) & ((64'd1 << sb) - 64'd1));
    ev = 1'b0;
    for (int w = 0; w < nw; w++)
      if (sh_valid[s][w] && sh_tag[s][w] == tg) begin
        promote_way(s, w);
        return 1'b1;
      end
    victim = nw;
    for (int w = 0; w < nw; w++)
      if (!sh_valid[s][w]) begin
        victim = w;
        break;
      end
    if (victim == nw) begin
      victim = 0;
      for (int w = 1; w < nw; w++)
        if (sh_rank[s][w] < sh_rank[s][victim]) victim = w;
      ev = 1'b1;
    end
    sh_valid[s][victim] = 1'b1;
    sh_tag[s][victim] = tg;
    promote_way(s, victim);
    return 1'b0;
  endfunction

  function automatic access_result_t predict_access(logic [1:0] act, logic [63:0] addr);
    access_result_t r;
    bit ev;
    r = '0;
    if (act != ACT_IFETCH) begin
      if (lookup_line(addr, ev)) begin
        r.hits_added = 2'd1;
        sh_hits = sat_add(sh_hits);
      end else begin
        r.missed = 1'b1;
        sh_misses = sat_add(sh_misses);
        if (ev) begin
          r.evicted = 1'b1;
          sh_evicts = sat_add(sh_evicts);
        end
      end
      // modify: the store half always finds the line
      if (act == ACT_MODIFY && lookup_line(addr, ev)) begin
        r.hits_added = r.hits_added + 2'd1;
        sh_hits = sat_add(sh_hits);
      end
    end
    r.total_hits = sh_hits;
    r.total_misses = sh_misses;
    r.total_evictions = sh_evicts;
    return r;
  endfunction

  // Send one beat; prediction happens at acceptance. Valid stays high after
  // the accept so that the next beat can follow; gaps and drain drop it.
  task automatic send_access(logic [1:0] act, logic [63:0] addr, bit gaps = 1'b1);
    if (gaps && $urandom_range(0, 3) == 0) begin
      int n;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(predict_access(act, addr));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write a register; only between phases with nothing in flight.
  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SET_BITS:   cf_set_bits = val & 5'h7;
      REG_BLOCK_BITS: cf_block_bits = val;
      REG_WAYS:       cf_ways = val & 5'hF;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int sb, int bb, int nw);
    write_reg(REG_SET_BITS, sb[4:0]);
    write_reg(REG_BLOCK_BITS, bb[4:0]);
    write_reg(REG_WAYS, nw[4:0]);
  endtask

  // Address mostly drawn from a small pool of tags so that hits and evictions recur.
  function automatic logic [63:0] pool_addr(int n_tags);
    logic [63:0] a;
    int unsigned sb;
    sb = (cf_set_bits > 6) ? 6 : cf_set_bits;
    a = {$urandom, $urandom};
    if ($urandom_range(0, 9) != 0) begin
      a = (64'($urandom_range(0, n_tags - 1)) << (sb + cf_block_bits))
        | (a & ((64'd1 << (sb + cf_block_bits)) - 64'd1));
      if ($urandom_range(0, 7) == 0) a[63] = 1'b1;
    end
    return a;
  endfunction

  function automatic logic [1:0] pick_action();
    int r;
    r = $urandom_range(0, 9);
    return (r == 0) ? ACT_IFETCH : (r < 4) ? ACT_LOAD : (r < 7) ? ACT_STORE : ACT_MODIFY;
  endfunction

  task automatic test_directed;
    send_access(ACT_LOAD, 64'd0);
    send_access(ACT_LOAD, 64'd0);
    send_access(ACT_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(ACT_MODIFY, 64'h8000_0000_0000_0000);
    send_access(ACT_IFETCH, 64'h1234_5678_9ABC_DEF0);
    send_access(ACT_MODIFY, 64'h8000_0000_0000_0000);
    send_access(ACT_LOAD, 64'h5555_5555_5555_5555);
    send_access(ACT_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
    // set bits above the maximum, block bits at their maximum
    set_geometry(7, 31, 8);
    send_access(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(ACT_LOAD, 64'h0);
    send_access(ACT_MODIFY, 64'h7FFF_FFFF_0000_0000);
    // ways of zero and above the maximum
    set_geometry(1, 4, 0);
    send_access(ACT_LOAD, 64'h100);
    send_access(ACT_LOAD, 64'h200);
    send_access(ACT_LOAD, 64'h100);
    set_geometry(1, 4, 15);
    for (int i = 0; i < 10; i++) send_access(ACT_STORE, 64'(i) << 5);
  endtask

  task automatic test_random_geometries;
    int cfgs[6][3] = '{'{0, 0, 1}, '{6, 16, 8}, '{2, 3, 4}, '{3, 6, 2}, '{6, 0, 8}, '{1, 16, 3}};
    foreach (cfgs[k]) begin
      set_geometry(cfgs[k][0], cfgs[k][1], cfgs[k][2]);
      repeat (220) send_access(pick_action(), pool_addr(cfgs[k][2] + 3));
    end
    // shrink ways below filled lines, then raise them again
    set_geometry(2, 2, 3);
    repeat (60) send_access(pick_action(), pool_addr(10));
    set_geometry(2, 2, 8);
    repeat (80) send_access(pick_action(), pool_addr(10));
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (30) send_access(pick_action(), pool_addr(6), 1'b0);
    join
    drain();   // sender pauses until all results are back
    repeat (200) send_access(pick_action(), pool_addr(6), 1'b0);
  endtask

  // Receiver: random stalls, no stalls in some stretches.
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if ($urandom_range(0, 63) < 8) out_tready <= $urandom_range(0, 1);
    else if ($urandom_range(0, 3) == 0) out_tready <= 1'b1;
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      access_result_t got, exp;
      got = out_tdata[99:0];
      // reorder into the struct's field order
      got.hits_added = out_tdata[1:0];
      got.missed = out_tdata[2];
      got.evicted = out_tdata[3];
      got.total_hits = out_tdata[35:4];
      got.total_misses = out_tdata[67:36];
      got.total_evictions = out_tdata[99:68];
      if (expected_results.size() == 0) begin
        $error("output beat with nothing expected");
        failed = 1'b1;
      end else begin
        exp = expected_results.pop_front();
        if (got.hits_added !== exp.hits_added) begin
          $error("hits_added exp %0d got %0d", exp.hits_added, got.hits_added);
          failed = 1'b1;
        end
        if (got.missed !== exp.missed) begin
          $error("missed exp %0d got %0d", exp.missed, got.missed);
          failed = 1'b1;
        end
        if (got.evicted !== exp.evicted) begin
          $error("evicted exp %0d got %0d", exp.evicted, got.evicted);
          failed = 1'b1;
        end
        if (got.total_hits !== exp.total_hits) begin
          $error("total_hits exp %0d got %0d", exp.total_hits, got.total_hits);
          failed = 1'b1;
        end
        if (got.total_misses !== exp.total_misses) begin
          $error("total_misses exp %0d got %0d", exp.total_misses, got.total_misses);
          failed = 1'b1;
        end
        if (got.total_evictions !== exp.total_evictions) begin
          $error("total_evictions exp %0d got %0d", exp.total_evictions,
                 got.total_evictions);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted beat or register write.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("lru_set_assoc_cache_sim test failed");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < N_SETS; s++)
      for (int w = 0; w < N_WAYS; w++) begin
        sh_valid[s][w] = 1'b0;
        sh_tag[s][w] = '0;
        sh_rank[s][w] = w;
      end
    sh_hits = '0;
    sh_misses = '0;
    sh_evicts = '0;
    cf_set_bits = 0;
    cf_block_bits = 0;
    cf_ways = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_geometries();
    test_backpressure();
    drain();
    repeat (10) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("lru_set_assoc_cache_sim test passed");
    end else begin
      $display("lru_set_assoc_cache_sim test failed");
    end
    $finish;
  end

endmodule
